// ===== rtl/mfle_pkg.sv =====
// Shared types and constants for the monochrome framebuffer line and rectangle engine.
package mfle_pkg;

  localparam int ScreenWDefault = 128;
  localparam int ScreenHDefault = 64;
  localparam int PageRows       = 8;
  localparam logic [7:0] ClearByte = 8'h00;

  typedef enum logic [1:0] {
    ACT_LINE = 2'd0,
    ACT_RECT = 2'd1,
    ACT_CLS  = 2'd2,
    ACT_READ = 2'd3
  } action_e;

  typedef enum logic [7:0] {
    ST_INIT = 8'b0000_0001,
    ST_IDLE = 8'b0000_0010,
    ST_WIPE = 8'b0000_0100,
    ST_LPIX = 8'b0000_1000,
    ST_LWR  = 8'b0001_0000,
    ST_RRD  = 8'b0010_0000,
    ST_RWR  = 8'b0100_0000,
    ST_RDB  = 8'b1000_0000
  } state_e;

endpackage

// ===== rtl/mfle_ram.sv =====
// Single-port synchronous RAM with registered read data.
module mfle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mfle_pkg::ScreenWDefault *
                        ((mfle_pkg::ScreenHDefault + mfle_pkg::PageRows - 1) /
                         mfle_pkg::PageRows),
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mono_framebuffer_line_rect_engine.sv =====
// Top level: 1-bpp paged framebuffer; Bresenham lines, rectangle and screen clear, readout.
// A read byte passes through ST_RDB; a line visits each pixel in ST_LPIX, adding an ST_LWR
//   write per on-screen pixel; a rectangle reads (ST_RRD) and writes (ST_RWR) each touched
//   byte; clear screen writes every byte. Line pixels and rectangle bytes are each a
//   read-modify-write through the single RAM port, which sets the rate. One item at a time;
//   busy is high until done_o. Reset: the RAM is swept to zero, one byte a cycle, with busy
//   high. done_o pulses one cycle and cannot be stalled.
module mono_framebuffer_line_rect_engine #(
  parameter int SCREEN_W = mfle_pkg::ScreenWDefault,
  parameter int SCREEN_H = mfle_pkg::ScreenHDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action_i,
  input  logic signed [11:0] x_start_i,
  input  logic signed [11:0] y_start_i,
  input  logic signed [11:0] x_end_i,
  input  logic signed [11:0] y_end_i,
  input  logic [11:0]        rect_width_i,
  input  logic [11:0]        rect_height_i,
  input  logic [9:0]         read_index_i,
  output logic               done_o,
  output logic [7:0]         read_data_o
);

  localparam int PageCount  = (SCREEN_H + mfle_pkg::PageRows - 1) / mfle_pkg::PageRows;
  localparam int StoreBytes = SCREEN_W * PageCount;
  localparam int AW = $clog2(StoreBytes);
  localparam int CW = $clog2(SCREEN_W + 1);
  localparam int RW = $clog2(SCREEN_H + 1);
  localparam logic signed [13:0] WLim = 14'(SCREEN_W);
  localparam logic signed [13:0] HLim = 14'(SCREEN_H);

  mfle_pkg::state_e state_q, state_d;
  logic [AW-1:0]        sweep_q, sweep_d;
  logic signed [11:0]   x_q, x_d, y_q, y_d, xe_q, xe_d, ye_q, ye_d;
  logic [12:0]          dx_q, dx_d, dy_q, dy_d;
  logic                 sxn_q, sxn_d, syn_q, syn_d;
  logic signed [14:0]   err_q, err_d;
  logic [CW-1:0]        col_q, col_d, col_lo_q, col_lo_d, col_hi_q, col_hi_d;
  logic [RW-1:0]        row_lo_q, row_lo_d, row_hi_q, row_hi_d;
  logic [RW-4:0]        page_q, page_d, page_hi_q, page_hi_d;
  logic                 in_range_q, in_range_d;
  logic                 done_q, done_d;
  logic [7:0]           rdata_q, rdata_d;

  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [7:0]           mem_wdata, mem_rdata;

  // Line stepping terms
  logic signed [15:0]   e2, neg_dy, dx_s;
  logic                 step_x, step_y, at_end, pix_on;
  logic signed [11:0]   x_nx, y_nx;
  logic signed [14:0]   err_nx;
  logic [AW-1:0]        pix_addr;
  logic [7:0]           line_mask;

  // Command setup terms
  logic signed [12:0]   xdiff, ydiff;
  logic [12:0]          dx_new, dy_new;
  logic signed [13:0]   rx0, rx1, ry0, ry1, rc0, rc1, rr0, rr1, rr1_m1;
  logic                 rect_empty;

  // Rectangle walk terms
  logic [AW-1:0]        rect_addr;
  logic [7:0]           rect_mask;
  logic [CW-1:0]        col_nx;

  assign at_end  = (x_q == xe_q) && (y_q == ye_q);
  assign e2      = $signed({err_q, 1'b0});
  assign neg_dy  = -$signed(16'(dy_q));
  assign dx_s    = $signed(16'(dx_q));
  assign step_x  = e2 > neg_dy;
  assign step_y  = e2 < dx_s;
  assign x_nx    = step_x ? (sxn_q ? x_q - 12'sd1 : x_q + 12'sd1) : x_q;
  assign y_nx    = step_y ? (syn_q ? y_q - 12'sd1 : y_q + 12'sd1) : y_q;
  assign err_nx  = err_q - (step_x ? $signed(15'(dy_q)) : 15'sd0)
                         + (step_y ? $signed(15'(dx_q)) : 15'sd0);
  assign pix_on  = !x_q[11] && (x_q[10:0] < 11'(SCREEN_W)) &&
                   !y_q[11] && (y_q[10:0] < 11'(SCREEN_H));
  assign pix_addr  = AW'(x_q[10:0]) + AW'(y_q[7:3]) * AW'(SCREEN_W);
  assign line_mask = 8'd1 << y_q[2:0];

  assign xdiff  = 13'(x_end_i) - 13'(x_start_i);
  assign ydiff  = 13'(y_end_i) - 13'(y_start_i);
  assign dx_new = xdiff[12] ? 13'(-xdiff) : 13'(xdiff);
  assign dy_new = ydiff[12] ? 13'(-ydiff) : 13'(ydiff);

  assign rx0    = 14'(x_start_i);
  assign ry0    = 14'(y_start_i);
  assign rx1    = rx0 + $signed({2'b00, rect_width_i});
  assign ry1    = ry0 + $signed({2'b00, rect_height_i});
  assign rc0    = rx0[13] ? 14'sd0 : rx0;
  assign rr0    = ry0[13] ? 14'sd0 : ry0;
  assign rc1    = (rx1 > WLim) ? WLim : rx1;
  assign rr1    = (ry1 > HLim) ? HLim : ry1;
  assign rr1_m1 = rr1 - 14'sd1;
  assign rect_empty = (rc1 <= rc0) || (rr1 <= rr0);

  assign rect_addr = AW'(col_q) + AW'(page_q) * AW'(SCREEN_W);
  assign col_nx    = col_q + CW'(1);

  always_comb begin
    logic [RW-1:0] row;
    row = '0;
    for (int n = 0; n < 8; n++) begin
      row = {page_q, 3'(n)};
      rect_mask[n] = (row >= row_lo_q) && (row < row_hi_q);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = mfle_pkg::ClearByte;
    case (state_q)
      mfle_pkg::ST_INIT, mfle_pkg::ST_WIPE: begin
        mem_we   = 1'b1;
        mem_addr = sweep_q;
      end
      mfle_pkg::ST_IDLE: mem_addr = AW'(read_index_i);
      mfle_pkg::ST_LPIX: mem_addr = pix_addr;
      mfle_pkg::ST_LWR: begin
        mem_we    = 1'b1;
        mem_addr  = pix_addr;
        mem_wdata = mem_rdata | line_mask;
      end
      mfle_pkg::ST_RRD: mem_addr = rect_addr;
      mfle_pkg::ST_RWR: begin
        mem_we    = 1'b1;
        mem_addr  = rect_addr;
        mem_wdata = mem_rdata & ~rect_mask;
      end
      default: mem_addr = '0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    x_d        = x_q;
    y_d        = y_q;
    xe_d       = xe_q;
    ye_d       = ye_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    sxn_d      = sxn_q;
    syn_d      = syn_q;
    err_d      = err_q;
    col_d      = col_q;
    col_lo_d   = col_lo_q;
    col_hi_d   = col_hi_q;
    row_lo_d   = row_lo_q;
    row_hi_d   = row_hi_q;
    page_d     = page_q;
    page_hi_d  = page_hi_q;
    in_range_d = in_range_q;
    done_d     = 1'b0;
    rdata_d    = rdata_q;
    case (state_q)
      mfle_pkg::ST_INIT: begin
        sweep_d = sweep_q + AW'(1);
        if (sweep_q == AW'(StoreBytes - 1)) begin
          state_d = mfle_pkg::ST_IDLE;
        end
      end
      mfle_pkg::ST_IDLE: begin
        if (start) begin
          rdata_d = 8'h00;
          case (mfle_pkg::action_e'(action_i))
            mfle_pkg::ACT_LINE: begin
              x_d     = x_start_i;
              y_d     = y_start_i;
              xe_d    = x_end_i;
              ye_d    = y_end_i;
              dx_d    = dx_new;
              dy_d    = dy_new;
              sxn_d   = !(x_start_i < x_end_i);
              syn_d   = !(y_start_i < y_end_i);
              err_d   = $signed(15'(dx_new)) - $signed(15'(dy_new));
              state_d = mfle_pkg::ST_LPIX;
            end
            mfle_pkg::ACT_RECT: begin
              col_lo_d  = CW'(rc0);
              col_d     = CW'(rc0);
              col_hi_d  = CW'(rc1);
              row_lo_d  = RW'(rr0);
              row_hi_d  = RW'(rr1);
              page_d    = rr0[RW-1:3];
              page_hi_d = rr1_m1[RW-1:3];
              if (rect_empty) begin
                done_d = 1'b1;
              end else begin
                state_d = mfle_pkg::ST_RRD;
              end
            end
            mfle_pkg::ACT_CLS: begin
              sweep_d = '0;
              state_d = mfle_pkg::ST_WIPE;
            end
            mfle_pkg::ACT_READ: begin
              in_range_d = 32'(read_index_i) < 32'(StoreBytes);
              state_d    = mfle_pkg::ST_RDB;
            end
            default: state_d = mfle_pkg::ST_IDLE;
          endcase
        end
      end
      mfle_pkg::ST_WIPE: begin
        sweep_d = sweep_q + AW'(1);
        if (sweep_q == AW'(StoreBytes - 1)) begin
          done_d  = 1'b1;
          state_d = mfle_pkg::ST_IDLE;
        end
      end
      mfle_pkg::ST_LPIX: begin
        if (pix_on) begin
          state_d = mfle_pkg::ST_LWR;
        end else if (at_end) begin
          done_d  = 1'b1;
          state_d = mfle_pkg::ST_IDLE;
        end else begin
          x_d   = x_nx;
          y_d   = y_nx;
          err_d = err_nx;
        end
      end
      mfle_pkg::ST_LWR: begin
        if (at_end) begin
          done_d  = 1'b1;
          state_d = mfle_pkg::ST_IDLE;
        end else begin
          x_d     = x_nx;
          y_d     = y_nx;
          err_d   = err_nx;
          state_d = mfle_pkg::ST_LPIX;
        end
      end
      mfle_pkg::ST_RRD: state_d = mfle_pkg::ST_RWR;
      mfle_pkg::ST_RWR: begin
        state_d = mfle_pkg::ST_RRD;
        if (col_nx == col_hi_q) begin
          col_d = col_lo_q;
          if (page_q == page_hi_q) begin
            done_d  = 1'b1;
            state_d = mfle_pkg::ST_IDLE;
          end else begin
            page_d = page_q + (RW-3)'(1);
          end
        end else begin
          col_d = col_nx;
        end
      end
      mfle_pkg::ST_RDB: begin
        rdata_d = in_range_q ? mem_rdata : 8'h00;
        done_d  = 1'b1;
        state_d = mfle_pkg::ST_IDLE;
      end
      default: state_d = mfle_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfle_pkg::ST_INIT;
      sweep_q <= '0;
      done_q  <= 1'b0;
      rdata_q <= 8'h00;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      done_q  <= done_d;
      rdata_q <= rdata_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    xe_q       <= xe_d;
    ye_q       <= ye_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    sxn_q      <= sxn_d;
    syn_q      <= syn_d;
    err_q      <= err_d;
    col_q      <= col_d;
    col_lo_q   <= col_lo_d;
    col_hi_q   <= col_hi_d;
    row_lo_q   <= row_lo_d;
    row_hi_q   <= row_hi_d;
    page_q     <= page_d;
    page_hi_q  <= page_hi_d;
    in_range_q <= in_range_d;
  end

  mfle_ram #(
    .WIDTH(8),
    .DEPTH(StoreBytes)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign busy        = (state_q != mfle_pkg::ST_IDLE);
  assign done_o      = done_q;
  assign read_data_o = done_q ? rdata_q : 8'h00;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("done_o while a command is still running");

  a_no_early_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i != mfle_pkg::ACT_RECT) |=> !done_o)
    else $error("done_o in the cycle right after accept");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfle_pkg::ST_IDLE) |-> !mem_we)
    else $error("framebuffer written while idle");

  a_lwr_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfle_pkg::ST_LWR) |-> ($past(state_q) == mfle_pkg::ST_LPIX && $stable(x_q)
                                       && $stable(y_q)))
    else $error("pixel write without matching read");

  a_rwr_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfle_pkg::ST_RWR) |-> ($past(state_q) == mfle_pkg::ST_RRD && $stable(col_q)
                                       && $stable(page_q)))
    else $error("rectangle write without matching read");

endmodule

// ===== dv/mfle_result_checker.sv =====
// Checker for the framebuffer engine: shadows the frame store, predicts read data, compares items.
module mfle_result_checker
  import mfle_pkg::*;
#(
  parameter int SCREEN_W = ScreenWDefault,
  parameter int SCREEN_H = ScreenHDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         action_i,
  input  logic signed [11:0] x_start_i,
  input  logic signed [11:0] y_start_i,
  input  logic signed [11:0] x_end_i,
  input  logic signed [11:0] y_end_i,
  input  logic [11:0]        rect_width_i,
  input  logic [11:0]        rect_height_i,
  input  logic [9:0]         read_index_i,
  input  logic               done_i,
  input  logic [7:0]         read_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PageCount  = (SCREEN_H + PageRows - 1) / PageRows;
  localparam int StoreBytes = SCREEN_W * PageCount;

  typedef struct {
    action_e    act;
    logic [9:0] index;
    logic [7:0] data;
  } read_expect_t;

  logic [7:0]   shadow_fb [StoreBytes];
  read_expect_t read_data_q [$];

  function automatic void mark_dot(int x, int y);
    if (x < 0 || x >= SCREEN_W || y < 0 || y >= SCREEN_H) return;
    shadow_fb[x + (y / PageRows) * SCREEN_W] |= 8'(1 << (y % PageRows));
  endfunction

  function automatic void walk_segment(int x, int y, int xe, int ye);
    int dx, dy, sx, sy, err, e2;
    dx  = (xe > x) ? xe - x : x - xe;
    dy  = (ye > y) ? ye - y : y - ye;
    sx  = (x < xe) ? 1 : -1;
    sy  = (y < ye) ? 1 : -1;
    err = dx - dy;
    // Walk the whole line; off-screen pixels are dropped by mark_dot
    forever begin
      mark_dot(x, y);
      if (x == xe && y == ye) break;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x   += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y   += sy;
      end
    end
  endfunction

  function automatic void wipe_area(int x, int y, int w, int h);
    int         c0, r0, c1, r1;
    logic [7:0] keep;
    c0 = (x < 0) ? 0 : x;
    r0 = (y < 0) ? 0 : y;
    c1 = (x + w > SCREEN_W) ? SCREEN_W : x + w;
    r1 = (y + h > SCREEN_H) ? SCREEN_H : y + h;
    for (int r = r0; r < r1; r++) begin
      keep = ~8'(1 << (r % PageRows));
      for (int c = c0; c < c1; c++) begin
        shadow_fb[c + (r / PageRows) * SCREEN_W] &= keep;
      end
    end
  endfunction

  function automatic logic [7:0] predict_read_data(action_e act);
    logic [7:0] data;
    data = ClearByte;
    case (act)
      ACT_LINE: walk_segment(int'(x_start_i), int'(y_start_i), int'(x_end_i), int'(y_end_i));
      ACT_RECT: wipe_area(int'(x_start_i), int'(y_start_i),
                          int'(rect_width_i), int'(rect_height_i));
      ACT_CLS: begin
        foreach (shadow_fb[i]) shadow_fb[i] = ClearByte;
      end
      default: begin
        // An index past the store reads as zero
        if (int'(read_index_i) < StoreBytes) data = shadow_fb[read_index_i];
      end
    endcase
    return data;
  endfunction

  function automatic void note_mismatch(string what);
    if (fail_count_o < 10) $display("%t %s", $realtime, what);
    fail_count_o++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    read_expect_t head;
    read_expect_t item;
    if (!rst_ni) begin
      fail_count_o = 0;
      read_data_q.delete();
      foreach (shadow_fb[i]) shadow_fb[i] = ClearByte;
    end else begin
      // Retire the finished item before taking a new one on the same edge
      if (done_i) begin
        if (read_data_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result: read_data %02h", read_data_i));
        end else begin
          head = read_data_q.pop_front();
          if (read_data_i !== head.data) begin
            note_mismatch($sformatf("read_data mismatch on %s index %0d: expected %02h got %02h",
                                    head.act.name(), head.index, head.data, read_data_i));
          end
        end
      end
      if (start_i && !busy_i) begin
        item.act   = action_e'(action_i);
        item.index = read_index_i;
        item.data  = predict_read_data(item.act);
        read_data_q.push_back(item);
      end
    end
    pending_o = read_data_q.size();
  end

endmodule

// ===== dv/mono_framebuffer_line_rect_engine_tb.sv =====
// Testbench top for the framebuffer engine: drives commands, runs the watchdog, reports.
module mono_framebuffer_line_rect_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfle_pkg::*;

  localparam int IdleLimit = 200000;
  localparam int NumRandom = 1230;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         action;
  logic signed [11:0] x_start;
  logic signed [11:0] y_start;
  logic signed [11:0] x_end;
  logic signed [11:0] y_end;
  logic [11:0]        rect_width;
  logic [11:0]        rect_height;
  logic [9:0]         read_index;
  logic               done;
  logic [7:0]         read_data;
  int                 fail_count;
  int                 pending;

  bit gaps_on;
  int last_x;
  int last_y;

  mono_framebuffer_line_rect_engine u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action),
    .x_start_i    (x_start),
    .y_start_i    (y_start),
    .x_end_i      (x_end),
    .y_end_i      (y_end),
    .rect_width_i (rect_width),
    .rect_height_i(rect_height),
    .read_index_i (read_index),
    .done_o       (done),
    .read_data_o  (read_data)
  );

  mfle_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .action_i     (action),
    .x_start_i    (x_start),
    .y_start_i    (y_start),
    .x_end_i      (x_end),
    .y_end_i      (y_end),
    .rect_width_i (rect_width),
    .rect_height_i(rect_height),
    .read_index_i (read_index),
    .done_i       (done),
    .read_data_i  (read_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4 clk_i = ~clk_i;

  task automatic send_item(input action_e act, input logic signed [11:0] xs, ys, xe, ye,
                           input logic [11:0] w, h, input logic [9:0] idx);
    int gap;
    if (gaps_on && $urandom_range(0, 99) < 28) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start       <= 1'b1;
    action      <= act;
    x_start     <= xs;
    y_start     <= ys;
    x_end       <= xe;
    y_end       <= ye;
    rect_width  <= w;
    rect_height <= h;
    read_index  <= idx;
    // Hold the item until the engine takes it
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [11:0] rand_coord();
    int v;
    if ($urandom_range(0, 99) < 3) return 12'($urandom);
    v = int'($urandom_range(0, 167)) - 20;
    return v[11:0];
  endfunction

  function automatic logic [11:0] rand_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) return 12'($urandom);
    if (pick < 12) return 12'($urandom_range(0, 200));
    return 12'($urandom_range(0, 40));
  endfunction

  function automatic logic [9:0] rand_index();
    // Favor the byte under the last line endpoint so reads see set pixels
    if ($urandom_range(0, 1) == 1 && last_x >= 0 && last_x < ScreenWDefault &&
        last_y >= 0 && last_y < ScreenHDefault) begin
      return 10'((last_y / PageRows) * ScreenWDefault + last_x);
    end
    return 10'($urandom_range(0, 1023));
  endfunction

  initial begin
    logic signed [11:0] xs, ys, xe, ye;
    int                 pick;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    action      = ACT_LINE;
    x_start     = '0;
    y_start     = '0;
    x_end       = '0;
    y_end       = '0;
    rect_width  = '0;
    rect_height = '0;
    read_index  = '0;
    gaps_on     = 1'b1;
    last_x      = -1;
    last_y      = -1;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: corners, clipping, degenerate shapes, full-range walks
    send_item(ACT_READ, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 10'd0);
    send_item(ACT_READ, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 10'd1023);
    send_item(ACT_LINE, 12'h000, 12'h000, 12'h000, 12'h000, 12'hFFF, 12'hFFF, 10'h3FF);
    send_item(ACT_READ, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 10'd0);
    send_item(ACT_LINE, 12'd127, 12'd63, 12'd127, 12'd63, 12'h000, 12'h000, 10'd0);
    send_item(ACT_READ, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 10'd1023);
    send_item(ACT_LINE, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'h000, 10'd0);
    send_item(ACT_LINE, 12'd128, 12'd64, 12'd128, 12'd64, 12'h000, 12'h000, 10'd0);
    send_item(ACT_LINE, 12'h800, 12'h800, 12'h7FF, 12'h7FF, 12'h000, 12'h000, 10'd0);
    send_item(ACT_READ, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 10'd136);
    send_item(ACT_LINE, 12'd0, 12'd5, 12'd127, 12'd5, 12'h000, 12'h000, 10'd0);
    send_item(ACT_LINE, 12'd3, 12'd0, 12'd3, 12'd63, 12'h000, 12'h000, 10'd0);
    send_item(ACT_LINE, 12'd100, 12'd60, 12'd10, 12'd2, 12'h000, 12'h000, 10'd0);
    send_item(ACT_READ, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 10'd3);
    send_item(ACT_READ, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 10'd131);
    send_item(ACT_RECT, 12'd0, 12'd0, 12'h000, 12'h000, 12'd0, 12'd10, 10'd0);
    send_item(ACT_RECT, 12'd0, 12'd0, 12'h000, 12'h000, 12'd10, 12'd0, 10'd0);
    send_item(ACT_READ, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 10'd3);
    send_item(ACT_RECT, 12'hFFB, 12'hFFB, 12'h000, 12'h000, 12'd20, 12'd20, 10'd0);
    send_item(ACT_READ, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 10'd3);
    send_item(ACT_RECT, 12'h7FF, 12'h7FF, 12'h000, 12'h000, 12'hFFF, 12'hFFF, 10'd0);
    send_item(ACT_RECT, 12'h800, 12'h800, 12'h000, 12'h000, 12'hFFF, 12'hFFF, 10'd0);
    send_item(ACT_READ, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 10'd136);
    send_item(ACT_LINE, 12'h7FF, 12'h800, 12'h800, 12'h7FF, 12'h000, 12'h000, 10'd0);
    send_item(ACT_CLS, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 10'd0);
    send_item(ACT_READ, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 10'd520);
    wait_drained();

    for (int n = 0; n < NumRandom; n++) begin
      gaps_on = !(n >= 500 && n < 700);
      if (n == 400 || n == 900) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        xs = rand_coord();
        ys = rand_coord();
        xe = rand_coord();
        ye = rand_coord();
        last_x = ($urandom_range(0, 1) == 1) ? int'(xs) : int'(xe);
        last_y = (last_x == int'(xs)) ? int'(ys) : int'(ye);
        send_item(ACT_LINE, xs, ys, xe, ye, 12'($urandom), 12'($urandom), 10'($urandom));
      end else if (pick < 62) begin
        send_item(ACT_RECT, rand_coord(), rand_coord(), 12'($urandom), 12'($urandom),
                  rand_size(), rand_size(), 10'($urandom));
      end else if (pick < 64) begin
        send_item(ACT_CLS, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                  12'($urandom), 12'($urandom), 10'($urandom));
      end else begin
        send_item(ACT_READ, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                  12'($urandom), 12'($urandom), rand_index());
      end
    end

    wait_drained();
    repeat (32) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || done) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

endmodule
